// ===== src/arm64_pc_relative_relocator_assert.svh =====
// Assertion macros used by the checker file.
`ifndef ARM64_PC_RELATIVE_RELOCATOR_ASSERT_SVH
`define ARM64_PC_RELATIVE_RELOCATOR_ASSERT_SVH

// Clocked assertion, muted while reset is applied.
`define ARL_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked through reset.
`define ARL_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/arl_pkg.sv =====
package arl_pkg;

    // Instruction class codes reported with each result.
    typedef enum logic [2:0] {
        CLS_OTHER  = 3'd0,
        CLS_B      = 3'd1,
        CLS_CB     = 3'd2,
        CLS_TB     = 3'd3,
        CLS_BCOND  = 3'd4,
        CLS_ADR    = 3'd5,
        CLS_ADRP   = 3'd6,
        CLS_LDRLIT = 3'd7
    } t_insn_class;

    // One input beat.
    typedef struct packed {
        logic [31:0] instruction_word;
        logic [63:0] source_address;
        logic [63:0] dest_address;
    } t_in_item;

    // One result beat.
    typedef struct packed {
        logic [31:0] relocated_word;
        t_insn_class insn_class;
        logic        offset_overflow;
    } t_out_item;

    // Opcode match masks and patterns.
    localparam logic [31:0] B_MASK      = 32'h7C00_0000;
    localparam logic [31:0] B_PAT       = 32'h1400_0000;
    localparam logic [31:0] CB_MASK     = 32'h7E00_0000;
    localparam logic [31:0] CB_PAT      = 32'h3400_0000;
    localparam logic [31:0] TB_PAT      = 32'h3600_0000;
    localparam logic [31:0] BYTE3_MASK  = 32'hFF00_0000;
    localparam logic [31:0] BCOND_PAT   = 32'h5400_0000;
    localparam logic [31:0] LDRLIT_PAT  = 32'h5800_0000;
    localparam logic [31:0] ADR_MASK    = 32'h9F00_0000;
    localparam logic [31:0] ADR_PAT     = 32'h1000_0000;
    localparam logic [31:0] ADRP_PAT    = 32'h9000_0000;

    // Low address bits dropped for a 4 KiB page.
    localparam int PAGE_BITS = 12;

    // Pipeline depth from accepted beat to result strobe.
    localparam int LATENCY = 3;

endpackage

// ===== src/arm64_pc_relative_relocator.sv =====
// AArch64 PC-relative instruction relocator.
// Input channel: drive i_in (instruction word, original address, new address)
// and raise start; the beat is taken at a rising edge where start is high and
// busy is low. busy is high while reset is applied and in the first cycle after
// it is released; from then on a new instruction can be taken every cycle.
// Result channel: o_out (rewritten word, class code, out-of-range flag) shows
// for exactly one cycle with o_strobe high. The receiver cannot stall, so the
// result must be captured in that cycle.
// Throughput is one instruction per cycle. The stages are: input register,
// opcode decode with address difference (64-bit byte and page subtracts),
// immediate add with range check and repack (one 64-bit add), result
// register.
// Reset (i_rst_n low, synchronous) drops every beat in flight and clears the
// strobe; payload registers are not cleared.
module arm64_pc_relative_relocator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  arl_pkg::t_in_item i_in,
    output arl_pkg::t_out_item o_out,
    output logic              o_strobe
);

    // Ready flag, set at the first clock edge after reset is released.
    logic r_rdy;

    // Stage 1: captured input beat.
    logic              r_v1;
    arl_pkg::t_in_item r_in1;

    // Stage 2: decoded class and scaled address difference.
    logic                  r_v2;
    logic [31:0]           r_word2;
    arl_pkg::t_insn_class  r_cls2;
    logic [63:0]           r_diff2;

    // Stage 3: result register.
    logic               r_strobe;
    arl_pkg::t_out_item r_out;

    logic                 n_v1;
    logic                 accept;
    arl_pkg::t_insn_class n_cls2;
    logic [63:0]          n_diff2;
    logic [63:0]          byte_diff;
    logic [63:0]          page_diff;
    logic [31:0]          w1;

    logic [63:0]        imm_ext;
    logic [63:0]        q;
    arl_pkg::t_out_item n_out;

    assign accept = start && r_rdy;
    assign n_v1   = accept;
    assign busy   = !r_rdy;
    assign w1     = r_in1.instruction_word;

    // Decode the opcode in priority order.
    always_comb begin
        priority if ((w1 & arl_pkg::B_MASK) == arl_pkg::B_PAT) begin
            n_cls2 = arl_pkg::CLS_B;
        end else if ((w1 & arl_pkg::CB_MASK) == arl_pkg::CB_PAT) begin
            n_cls2 = arl_pkg::CLS_CB;
        end else if ((w1 & arl_pkg::CB_MASK) == arl_pkg::TB_PAT) begin
            n_cls2 = arl_pkg::CLS_TB;
        end else if ((w1 & arl_pkg::BYTE3_MASK) == arl_pkg::BCOND_PAT) begin
            n_cls2 = arl_pkg::CLS_BCOND;
        end else if ((w1 & arl_pkg::ADR_MASK) == arl_pkg::ADR_PAT) begin
            n_cls2 = arl_pkg::CLS_ADR;
        end else if ((w1 & arl_pkg::ADR_MASK) == arl_pkg::ADRP_PAT) begin
            n_cls2 = arl_pkg::CLS_ADRP;
        end else if ((w1 & arl_pkg::BYTE3_MASK) == arl_pkg::LDRLIT_PAT) begin
            n_cls2 = arl_pkg::CLS_LDRLIT;
        end else begin
            n_cls2 = arl_pkg::CLS_OTHER;
        end
    end

    // Form the byte or page difference and scale it to immediate units.
    // The immediate term never touches the dropped low bits, so it is added later.
    assign byte_diff = r_in1.source_address - r_in1.dest_address;
    assign page_diff = {r_in1.source_address[63:arl_pkg::PAGE_BITS],
                        {arl_pkg::PAGE_BITS{1'b0}}}
                     - {r_in1.dest_address[63:arl_pkg::PAGE_BITS],
                        {arl_pkg::PAGE_BITS{1'b0}}};

    always_comb begin
        unique case (n_cls2)
            arl_pkg::CLS_ADR:  n_diff2 = byte_diff;
            arl_pkg::CLS_ADRP: n_diff2 = {{arl_pkg::PAGE_BITS{page_diff[63]}},
                                          page_diff[63:arl_pkg::PAGE_BITS]};
            default:           n_diff2 = {{2{byte_diff[63]}}, byte_diff[63:2]};
        endcase
    end

    // Pick the sign-extended original immediate.
    always_comb begin
        unique case (r_cls2)
            arl_pkg::CLS_B:
                imm_ext = {{38{r_word2[25]}}, r_word2[25:0]};
            arl_pkg::CLS_TB:
                imm_ext = {{50{r_word2[18]}}, r_word2[18:5]};
            arl_pkg::CLS_ADR, arl_pkg::CLS_ADRP:
                imm_ext = {{43{r_word2[23]}}, r_word2[23:5], r_word2[30:29]};
            default:
                imm_ext = {{45{r_word2[23]}}, r_word2[23:5]};
        endcase
    end

    assign q = r_diff2 + imm_ext;

    // Repack the new immediate and flag values that do not fit the field.
    always_comb begin
        n_out.insn_class = r_cls2;
        unique case (r_cls2)
            arl_pkg::CLS_OTHER: begin
                n_out.relocated_word  = r_word2;
                n_out.offset_overflow = 1'b0;
            end
            arl_pkg::CLS_B: begin
                n_out.relocated_word  = {r_word2[31:26], q[25:0]};
                n_out.offset_overflow = !((&q[63:25]) || !(|q[63:25]));
            end
            arl_pkg::CLS_TB: begin
                n_out.relocated_word  = {r_word2[31:19], q[13:0], r_word2[4:0]};
                n_out.offset_overflow = !((&q[63:13]) || !(|q[63:13]));
            end
            arl_pkg::CLS_ADR, arl_pkg::CLS_ADRP: begin
                n_out.relocated_word  = {r_word2[31], q[1:0], r_word2[28:24],
                                         q[20:2], r_word2[4:0]};
                n_out.offset_overflow = !((&q[63:20]) || !(|q[63:20]));
            end
            default: begin
                n_out.relocated_word  = {r_word2[31:24], q[18:0], r_word2[4:0]};
                n_out.offset_overflow = !((&q[63:18]) || !(|q[63:18]));
            end
        endcase
    end

    // Advance the control flags; drop everything in flight on reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy    <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_rdy    <= 1'b1;
            r_v1     <= n_v1;
            r_v2     <= r_v1;
            r_strobe <= r_v2;
        end
    end

    // Advance the payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in1 <= i_in;
        end
        if (r_v1) begin
            r_word2 <= w1;
            r_cls2  <= n_cls2;
            r_diff2 <= n_diff2;
        end
        if (r_v2) begin
            r_out <= n_out;
        end
    end

    assign o_out    = r_out;
    assign o_strobe = r_strobe;

endmodule

// ===== src/arl_checker.sv =====
`include "arm64_pc_relative_relocator_assert.svh"

module arl_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input arl_pkg::t_in_item  i_in,
    input arl_pkg::t_out_item o_out,
    input logic               o_strobe
);

    // Every accepted beat yields a strobe after the pipeline delay.
    `ARL_ASSERT_CLK(a_accept_to_strobe, i_clk, i_rst_n, (start && !busy) |-> ##3 o_strobe, "accepted beat produced no result")

    // No strobe without an accepted beat at the matching earlier edge.
    `ARL_ASSERT_CLK(a_strobe_from_accept, i_clk, i_rst_n, o_strobe |-> $past(start && !busy, 3), "result without accepted beat")

    // Unrecognized words pass through untouched and never flag.
    `ARL_ASSERT_CLK(a_passthrough, i_clk, i_rst_n, (o_strobe && o_out.insn_class == arl_pkg::CLS_OTHER) |-> (o_out.relocated_word == $past(i_in.instruction_word, 3) && !o_out.offset_overflow), "unrecognized word was altered")

    // Once out of reset the block is always ready.
    `ARL_ASSERT_ALWAYS(a_never_busy, i_clk, $past(i_rst_n) |-> !busy, "busy raised outside reset")

endmodule

bind arm64_pc_relative_relocator arl_checker u_arl_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_in     (i_in),
    .o_out    (o_out),
    .o_strobe (o_strobe)
);
